/* hw/rtl/cdq_pkg.sv */
// cdq_pkg: shared constants, codes and the command type of the circular deque.
// No dependencies; used by the interfaces and every module of the block.
package cdq_pkg;

  // Storage geometry
  localparam int DEPTH     = 16;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // Field widths
  localparam int WORD_W    = 32;
  localparam int OPC_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int OUT_CNT_W = 5;

  // Command queue between front and back
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // Opcodes
  localparam logic [OPC_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPC_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPC_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPC_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPC_W-1:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [OPC_W-1:0] OP_PEEK_BACK  = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Command kinds after decode
  localparam logic [1:0] CMD_NOP  = 2'd0;
  localparam logic [1:0] CMD_PUSH = 2'd1;
  localparam logic [1:0] CMD_POP  = 2'd2;
  localparam logic [1:0] CMD_PEEK = 2'd3;

  typedef struct packed {
    logic [1:0]               kind;
    logic                     at_back;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

endpackage

/* hw/rtl/cdq_ifs.sv */
// cdq_ifs: request and response channel interfaces of the circular deque.
// Depends on cdq_pkg for field widths.
interface cdq_req_if;
  logic                              valid;
  logic                              ready;
  logic [cdq_pkg::OPC_W-1:0]         opcode;
  logic signed [cdq_pkg::WORD_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface cdq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [cdq_pkg::WORD_W-1:0]   data;
  logic [cdq_pkg::STATUS_W-1:0]        status;
  logic                                is_full;
  logic                                is_empty;
  logic [cdq_pkg::OUT_CNT_W-1:0]       count;

  modport source (output valid, output data, output status, output is_full,
                  output is_empty, output count, input ready);
  modport sink   (input valid, input data, input status, input is_full,
                  input is_empty, input count, output ready);
endinterface

/* hw/rtl/circular_deque.sv */
// circular_deque: double-ended queue of signed words in a ring buffer.
// A request passes through the front command register, command queue, back execute
// stage and response register. Throughput: one request per cycle while the receiver
// is ready; the back unit updates the end indices in the same cycle it issues the
// storage access, so back-to-back commands see fresh state.
// Reset (rst_n, synchronous, active low): empty deque, front index 0, back index
// DEPTH-1, all stages empty. Storage is not cleared; only written slots are read.
module circular_deque (
  input  logic         clk,
  input  logic         rst_n,
  cdq_req_if.sink      in_chan,
  cdq_rsp_if.source    out_chan
);

  // front -> queue
  logic          f_valid, f_ready;
  cdq_pkg::cmd_t f_cmd;
  // queue -> back
  logic          q_valid, q_ready;
  cdq_pkg::cmd_t q_cmd;

  // Front: request decode into a command register
  cdq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_chan.valid),
    .req_ready  (in_chan.ready),
    .req_opcode (in_chan.opcode),
    .req_value  (in_chan.value),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  // Short command queue so front and back stall independently
  cdq_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  // Back: index/count update, ring storage access, response register
  cdq_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (q_valid),
    .cmd_ready    (q_ready),
    .cmd          (q_cmd),
    .rsp_valid    (out_chan.valid),
    .rsp_ready    (out_chan.ready),
    .rsp_data     (out_chan.data),
    .rsp_status   (out_chan.status),
    .rsp_is_full  (out_chan.is_full),
    .rsp_is_empty (out_chan.is_empty),
    .rsp_count    (out_chan.count)
  );

endmodule

/* hw/rtl/cdq_front.sv */
// cdq_front: accepts requests and decodes the opcode into a command.
// Depends on cdq_pkg.
module cdq_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [cdq_pkg::OPC_W-1:0]         req_opcode,
  input  logic signed [cdq_pkg::WORD_W-1:0] req_value,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output cdq_pkg::cmd_t                     cmd
);

  logic [1:0] kind;
  logic       at_back;

  always_comb begin
    kind    = cdq_pkg::CMD_NOP;
    at_back = 1'b0;
    case (req_opcode)
      cdq_pkg::OP_PUSH_FRONT: kind = cdq_pkg::CMD_PUSH;
      cdq_pkg::OP_PUSH_BACK: begin
        kind    = cdq_pkg::CMD_PUSH;
        at_back = 1'b1;
      end
      cdq_pkg::OP_POP_FRONT: kind = cdq_pkg::CMD_POP;
      cdq_pkg::OP_POP_BACK: begin
        kind    = cdq_pkg::CMD_POP;
        at_back = 1'b1;
      end
      cdq_pkg::OP_PEEK_FRONT: kind = cdq_pkg::CMD_PEEK;
      cdq_pkg::OP_PEEK_BACK: begin
        kind    = cdq_pkg::CMD_PEEK;
        at_back = 1'b1;
      end
      default: kind = cdq_pkg::CMD_NOP;
    endcase
  end

  // Registered command stage (skid-free: refills when empty or draining)
  logic          cmd_valid_r, cmd_valid_nxt;
  cdq_pkg::cmd_t cmd_r;
  logic          load;

  assign req_ready = !cmd_valid_r || cmd_ready;
  assign load      = req_valid && req_ready;

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    if (load) begin
      cmd_valid_nxt = 1'b1;
    end else if (cmd_ready) begin
      cmd_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r.kind    <= kind;
      cmd_r.at_back <= at_back;
      cmd_r.value   <= req_value;
    end
  end

  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

endmodule

/* hw/rtl/cdq_cmd_queue.sv */
// cdq_cmd_queue: short command FIFO that decouples front and back.
// Depends on cdq_pkg.
module cdq_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  cdq_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  logic          rd_ready,
  output cdq_pkg::cmd_t rd_cmd
);

  cdq_pkg::cmd_t               slot_r [cdq_pkg::QDEPTH];
  logic [cdq_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [cdq_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [cdq_pkg::QCNT_W-1:0]  fill_r, fill_nxt;
  logic                        push, pop;

  localparam logic [cdq_pkg::QPTR_W-1:0] PTR_LAST = cdq_pkg::QPTR_W'(cdq_pkg::QDEPTH - 1);
  localparam logic [cdq_pkg::QCNT_W-1:0] FILL_MAX = cdq_pkg::QCNT_W'(cdq_pkg::QDEPTH);

  assign wr_ready = (fill_r != FILL_MAX);
  assign rd_valid = (fill_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

/* hw/rtl/cdq_back.sv */
// cdq_back: executes deque commands against the ring storage and end indices,
// and holds the response register. Depends on cdq_pkg.
module cdq_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  cdq_pkg::cmd_t                       cmd,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic signed [cdq_pkg::WORD_W-1:0]   rsp_data,
  output logic [cdq_pkg::STATUS_W-1:0]        rsp_status,
  output logic                                rsp_is_full,
  output logic                                rsp_is_empty,
  output logic [cdq_pkg::OUT_CNT_W-1:0]       rsp_count
);

  // Deque state
  logic [cdq_pkg::IDX_W-1:0] front_r, front_nxt;
  logic [cdq_pkg::IDX_W-1:0] back_r, back_nxt;
  logic [cdq_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // Ring storage, no reset: entries are read only after a write
  logic signed [cdq_pkg::WORD_W-1:0] mem [cdq_pkg::DEPTH];
  logic signed [cdq_pkg::WORD_W-1:0] rd_data_r;
  logic [cdq_pkg::IDX_W-1:0]         wr_addr, rd_addr;
  logic                              wr_en;

  // Execute stage (waits on read data)
  logic                          pend_valid_r, pend_valid_nxt;
  logic                          pend_rd_r;
  logic [cdq_pkg::STATUS_W-1:0]  pend_status_r;
  logic [cdq_pkg::CNT_W-1:0]     pend_cnt_r;

  // Response register
  logic                              out_valid_r, out_valid_nxt;
  logic signed [cdq_pkg::WORD_W-1:0] out_data_r;
  logic [cdq_pkg::STATUS_W-1:0]      out_status_r;
  logic                              out_full_r, out_empty_r;
  logic [cdq_pkg::OUT_CNT_W-1:0]     out_cnt_r;

  logic                          take, pend_move, is_full, is_empty, rd_hit;
  logic [cdq_pkg::STATUS_W-1:0]  status;
  logic [cdq_pkg::IDX_W-1:0]     front_dec, back_inc, front_inc, back_dec;

  assign pend_move = pend_valid_r && (!out_valid_r || rsp_ready);
  assign cmd_ready = !pend_valid_r || pend_move;
  assign take      = cmd_valid && cmd_ready;

  assign is_full   = (cnt_r == cdq_pkg::CNT_FULL);
  assign is_empty  = (cnt_r == '0);
  assign front_dec = (front_r == '0) ? cdq_pkg::IDX_LAST : front_r - 1'b1;
  assign front_inc = (front_r == cdq_pkg::IDX_LAST) ? '0 : front_r + 1'b1;
  assign back_inc  = (back_r == cdq_pkg::IDX_LAST) ? '0 : back_r + 1'b1;
  assign back_dec  = (back_r == '0) ? cdq_pkg::IDX_LAST : back_r - 1'b1;

  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    cnt_nxt   = cnt_r;
    status    = cdq_pkg::ST_OK;
    wr_en     = 1'b0;
    wr_addr   = back_inc;
    rd_hit    = 1'b0;
    rd_addr   = cmd.at_back ? back_r : front_r;
    case (cmd.kind)
      cdq_pkg::CMD_PUSH: begin
        if (is_full) begin
          status = cdq_pkg::ST_FULL;
        end else begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (cmd.at_back) begin
            back_nxt = back_inc;
            wr_addr  = back_inc;
          end else if (is_empty) begin
            // first entry from the front lands at slot zero, both ends there
            front_nxt = '0;
            back_nxt  = '0;
            wr_addr   = '0;
          end else begin
            front_nxt = front_dec;
            wr_addr   = front_dec;
          end
        end
      end
      cdq_pkg::CMD_POP: begin
        if (is_empty) begin
          status = cdq_pkg::ST_EMPTY;
        end else begin
          rd_hit  = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == cdq_pkg::CNT_W'(1)) begin
            // drained: ends go back to their reset positions
            front_nxt = '0;
            back_nxt  = cdq_pkg::IDX_LAST;
          end else if (cmd.at_back) begin
            back_nxt = back_dec;
          end else begin
            front_nxt = front_inc;
          end
        end
      end
      cdq_pkg::CMD_PEEK: begin
        if (is_empty) begin
          status = cdq_pkg::ST_EMPTY;
        end else begin
          rd_hit = 1'b1;
        end
      end
      default: begin
        status = cdq_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (take) begin
      pend_valid_nxt = 1'b1;
    end else if (pend_move) begin
      pend_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (pend_move) begin
      out_valid_nxt = 1'b1;
    end else if (rsp_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r      <= '0;
      back_r       <= cdq_pkg::IDX_LAST;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        front_r <= front_nxt;
        back_r  <= back_nxt;
        cnt_r   <= cnt_nxt;
      end
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Storage port: one write, one registered read
  always_ff @(posedge clk) begin
    if (take && wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (take) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_rd_r     <= rd_hit;
      pend_status_r <= status;
      pend_cnt_r    <= cnt_nxt;
    end
    if (pend_move) begin
      out_data_r   <= pend_rd_r ? rd_data_r : '0;
      out_status_r <= pend_status_r;
      out_full_r   <= (pend_cnt_r == cdq_pkg::CNT_FULL);
      out_empty_r  <= (pend_cnt_r == '0);
      out_cnt_r    <= cdq_pkg::OUT_CNT_W'(pend_cnt_r);
    end
  end

  assign rsp_valid    = out_valid_r;
  assign rsp_data     = out_data_r;
  assign rsp_status   = out_status_r;
  assign rsp_is_full  = out_full_r;
  assign rsp_is_empty = out_empty_r;
  assign rsp_count    = out_cnt_r;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for circular_deque, driving random and directed requests.
// Depends on cdq_pkg and the cdq_req_if / cdq_rsp_if interfaces from the RTL.

typedef struct {
  logic signed [cdq_pkg::WORD_W-1:0] data;
  logic [cdq_pkg::STATUS_W-1:0]      status;
  logic                              is_full;
  logic                              is_empty;
  logic [cdq_pkg::OUT_CNT_W-1:0]     count;
} deque_rsp_t;

// Mirror of the deque contents; predicts each response and checks it on arrival.
class deque_shadow;
  logic signed [cdq_pkg::WORD_W-1:0] slots [cdq_pkg::DEPTH];
  logic [cdq_pkg::IDX_W-1:0]         head_idx;
  logic [cdq_pkg::IDX_W-1:0]         tail_idx;
  logic [cdq_pkg::CNT_W-1:0]         fill;
  deque_rsp_t                        pending[$];
  int unsigned                       accepted;
  int unsigned                       errors;

  function new();
    head_idx = '0;
    tail_idx = cdq_pkg::IDX_LAST;
    fill     = '0;
    accepted = 0;
    errors   = 0;
  endfunction

  function logic [cdq_pkg::IDX_W-1:0] idx_up(logic [cdq_pkg::IDX_W-1:0] i);
    return (i == cdq_pkg::IDX_LAST) ? '0 : i + 1'b1;
  endfunction

  function logic [cdq_pkg::IDX_W-1:0] idx_down(logic [cdq_pkg::IDX_W-1:0] i);
    return (i == '0) ? cdq_pkg::IDX_LAST : i - 1'b1;
  endfunction

  // Apply one operation to the mirror and return the response it must produce.
  function deque_rsp_t predict(logic [cdq_pkg::OPC_W-1:0] op,
                               logic signed [cdq_pkg::WORD_W-1:0] val);
    deque_rsp_t r;
    logic       was_full;
    logic       was_empty;
    was_full  = (fill == cdq_pkg::CNT_FULL);
    was_empty = (fill == '0);
    r.data    = '0;
    r.status  = cdq_pkg::ST_OK;
    case (op)
      cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_BACK: begin
        if (was_full) begin
          r.status = cdq_pkg::ST_FULL;
        end else begin
          if (op == cdq_pkg::OP_PUSH_BACK) begin
            tail_idx = idx_up(tail_idx);
            slots[tail_idx] = val;
          end else begin
            // first push at the front pins both ends to slot zero
            if (was_empty) begin
              head_idx = '0;
              tail_idx = '0;
            end else begin
              head_idx = idx_down(head_idx);
            end
            slots[head_idx] = val;
          end
          fill = fill + 1'b1;
        end
      end
      cdq_pkg::OP_POP_FRONT, cdq_pkg::OP_POP_BACK,
      cdq_pkg::OP_PEEK_FRONT, cdq_pkg::OP_PEEK_BACK: begin
        if (was_empty) begin
          r.status = cdq_pkg::ST_EMPTY;
        end else begin
          if (op == cdq_pkg::OP_POP_FRONT || op == cdq_pkg::OP_PEEK_FRONT)
            r.data = slots[head_idx];
          else
            r.data = slots[tail_idx];
          if (op == cdq_pkg::OP_POP_FRONT) begin
            head_idx = idx_up(head_idx);
            fill = fill - 1'b1;
          end else if (op == cdq_pkg::OP_POP_BACK) begin
            tail_idx = idx_down(tail_idx);
            fill = fill - 1'b1;
          end
          // drained: ends go back to their reset positions
          if (fill == '0) begin
            head_idx = '0;
            tail_idx = cdq_pkg::IDX_LAST;
          end
        end
      end
      default: ;
    endcase
    r.is_full  = (fill == cdq_pkg::CNT_FULL);
    r.is_empty = (fill == '0);
    r.count    = cdq_pkg::OUT_CNT_W'(fill);
    return r;
  endfunction

  function void note_request(logic [cdq_pkg::OPC_W-1:0] op,
                             logic signed [cdq_pkg::WORD_W-1:0] val);
    pending.push_back(predict(op, val));
    accepted++;
  endfunction

  function void check_response(deque_rsp_t got);
    deque_rsp_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: unexpected response data=%0d status=%0d count=%0d",
                 got.data, got.status, got.count);
      return;
    end
    want = pending.pop_front();
    if (got.data !== want.data || got.status !== want.status ||
        got.is_full !== want.is_full || got.is_empty !== want.is_empty ||
        got.count !== want.count) begin
      errors++;
      if (errors <= 10) begin
        $display("ERROR: response mismatch exp data=%0d st=%0d f=%0b e=%0b cnt=%0d",
                 want.data, want.status, want.is_full, want.is_empty, want.count);
        $display("       got data=%0d st=%0d f=%0b e=%0b cnt=%0d",
                 got.data, got.status, got.is_full, got.is_empty, got.count);
      end
    end
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int RANDOM_OPS     = 1000;
  localparam int HOLD_AT        = 300;   // accepted requests before the long receiver hold
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 12;

  // opcodes the block treats as no-ops
  localparam logic [cdq_pkg::OPC_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [cdq_pkg::OPC_W-1:0] OP_SPARE_7 = 3'd7;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_t;

  logic clk;
  logic rst_n;

  cdq_req_if req_bus();
  cdq_rsp_if rsp_bus();

  circular_deque DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_bus),
    .out_chan (rsp_bus)
  );

  deque_shadow shadow = new();

  int burst_left;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: the run must finish well inside the limit.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Response monitor: sampled at the rising edge, before any register updates land.
  always @(posedge clk) begin
    deque_rsp_t got;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      got.data     = rsp_bus.data;
      got.status   = rsp_bus.status;
      got.is_full  = rsp_bus.is_full;
      got.is_empty = rsp_bus.is_empty;
      got.count    = rsp_bus.count;
      shadow.check_response(got);
    end
  end

  // Receiver: segments of always-ready, coin-flip and mostly-stalled, plus one long
  // hold-off once enough requests have gone in, so the block backs up to its input.
  initial begin
    int  hold_left;
    int  seg_left;
    int  seg_mode;
    bit  held;
    hold_left = 0;
    seg_left  = 0;
    seg_mode  = 0;
    held      = 1'b0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && shadow.accepted >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 2);
          seg_left = $urandom_range(1, 40);
        end
        seg_left--;
        case (seg_mode)
          0: rsp_bus.ready <= 1'b1;
          1: rsp_bus.ready <= $urandom_range(0, 1);
          default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Values lean on the extremes now and then; otherwise fully random words.
  function automatic logic signed [cdq_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [cdq_pkg::OPC_W-1:0] pick_op(op_mix_t mix);
    int r;
    int side;
    r    = $urandom_range(0, 99);
    side = $urandom_range(0, 1);
    if ($urandom_range(0, 63) == 0)
      return side ? OP_SPARE_7 : OP_SPARE_6;
    case (mix)
      MIX_FILL: begin
        if (r < 75) return side ? cdq_pkg::OP_PUSH_BACK : cdq_pkg::OP_PUSH_FRONT;
        if (r < 88) return side ? cdq_pkg::OP_POP_BACK : cdq_pkg::OP_POP_FRONT;
        return side ? cdq_pkg::OP_PEEK_BACK : cdq_pkg::OP_PEEK_FRONT;
      end
      MIX_DRAIN: begin
        if (r < 70) return side ? cdq_pkg::OP_POP_BACK : cdq_pkg::OP_POP_FRONT;
        if (r < 85) return side ? cdq_pkg::OP_PUSH_BACK : cdq_pkg::OP_PUSH_FRONT;
        return side ? cdq_pkg::OP_PEEK_BACK : cdq_pkg::OP_PEEK_FRONT;
      end
      default: return cdq_pkg::OPC_W'($urandom_range(0, 5));
    endcase
  endfunction

  // Offer one request at the falling edge and hold it until the block takes it.
  // Between bursts the valid line drops for a random gap.
  task automatic send_request(logic [cdq_pkg::OPC_W-1:0] op,
                              logic signed [cdq_pkg::WORD_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      // occasionally a long unbroken run
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 30);
      gap = $urandom_range(1, 8);
      @(negedge clk);
      req_bus.valid  <= 1'b0;
      req_bus.opcode <= cdq_pkg::OPC_W'($urandom);
      req_bus.value  <= $urandom;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    req_bus.valid  <= 1'b1;
    req_bus.opcode <= op;
    req_bus.value  <= val;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    shadow.note_request(op, val);
  endtask

  initial begin
    op_mix_t mix;
    int      seg_left;
    int      issued;
    req_bus.valid  = 1'b0;
    req_bus.opcode = '0;
    req_bus.value  = '0;
    rst_n          = 1'b0;
    burst_left     = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-queue rejects, spare opcodes, front push into an empty queue,
    // word extremes at both ends, and draining from each end.
    send_request(cdq_pkg::OP_POP_FRONT,  32'sd1);
    send_request(cdq_pkg::OP_POP_BACK,   32'sd2);
    send_request(cdq_pkg::OP_PEEK_FRONT, 32'sd3);
    send_request(cdq_pkg::OP_PEEK_BACK,  32'sd4);
    send_request(OP_SPARE_6,             -32'sd1);
    send_request(OP_SPARE_7,             32'sh7FFF_FFFF);
    send_request(cdq_pkg::OP_PUSH_FRONT, 32'sh8000_0000);
    send_request(cdq_pkg::OP_PUSH_BACK,  32'sh7FFF_FFFF);
    send_request(cdq_pkg::OP_PUSH_FRONT, -32'sd1);
    send_request(cdq_pkg::OP_PEEK_FRONT, '0);
    send_request(cdq_pkg::OP_PEEK_BACK,  '0);
    send_request(OP_SPARE_6,             32'sh1234_5678);
    send_request(cdq_pkg::OP_POP_BACK,   '0);
    send_request(cdq_pkg::OP_POP_FRONT,  '0);
    send_request(cdq_pkg::OP_POP_FRONT,  -32'sd1);
    send_request(cdq_pkg::OP_PUSH_BACK,  '0);
    send_request(cdq_pkg::OP_PEEK_FRONT, '0);
    send_request(cdq_pkg::OP_POP_BACK,   '0);
    send_request(cdq_pkg::OP_PUSH_BACK,  32'sh5555_5555);
    send_request(cdq_pkg::OP_PUSH_FRONT, 32'shAAAA_AAAA);
    send_request(cdq_pkg::OP_POP_FRONT,  '0);
    send_request(cdq_pkg::OP_POP_FRONT,  '0);

    // Random: segments that push toward full, toward empty, or stay balanced.
    issued   = 0;
    seg_left = 0;
    mix      = MIX_FILL;
    while (issued < RANDOM_OPS) begin
      if (seg_left == 0) begin
        if (issued == 0) begin
          mix      = MIX_FILL;
          seg_left = 40;
        end else begin
          mix      = op_mix_t'($urandom_range(0, 2));
          seg_left = $urandom_range(10, 60);
        end
      end
      seg_left--;
      send_request(pick_op(mix), pick_word());
      issued++;
    end

    @(negedge clk);
    req_bus.valid <= 1'b0;

    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (shadow.errors == 0 && shadow.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

/* circular_deque.f */
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ifs.sv
hw/rtl/cdq_front.sv
hw/rtl/cdq_cmd_queue.sv
hw/rtl/cdq_back.sv
hw/rtl/circular_deque.sv
tb/testbench.sv
